// ----- sv/ptwfe_pkg.sv -----
// shared types, defaults and command/status bundles for the page table walker
package ptwfe_pkg;

  localparam int OFFSET_BITS        = 4;
  localparam int TABLE_LEVELS       = 4;
  localparam int FRAME_ADDRESS_BITS = 10;
  localparam int DATA_BITS          = 32;

  localparam int VA_BITS   = 32;
  localparam int WORD_BITS = 32;
  localparam int PA_BITS   = 10;

  typedef struct packed {
    logic                        kind;
    logic [VA_BITS-1:0]          vaddr;
    logic signed [WORD_BITS-1:0] write_data;
  } req_t;

  typedef struct packed {
    logic                        status;
    logic signed [WORD_BITS-1:0] read_data;
    logic [PA_BITS-1:0]          physical_address;
  } rsp_t;

  typedef enum logic [2:0] {
    FA_WALK, FA_DFS, FA_NF, FA_CUR, FA_PA, FA_CLR
  } fm_addr_t;

  typedef enum logic [1:0] {
    FW_ZERO, FW_NF, FW_SWAP, FW_DATA
  } fm_wsel_t;

  typedef enum logic [1:0] {
    SA_CLR, SA_OUT, SA_IN
  } sw_addr_t;

  typedef enum logic [1:0] {
    NF_EMPTY, NF_HIGH, NF_BEST
  } nf_src_t;

  typedef struct packed {
    logic     take_in;
    logic     fm_re;
    logic     fm_we;
    fm_addr_t fm_addr;
    fm_wsel_t fm_wsel;
    logic     sw_re;
    logic     sw_we;
    sw_addr_t sw_addr;
    logic     clr_step;
    logic     cnt_clr;
    logic     cnt_inc;
    logic     walk_start;
    logic     walk_adv;
    logic     link;
    logic     search_init;
    logic     dfs_init;
    logic     dfs_mark;
    logic     dfs_push;
    logic     dfs_next;
    logic     dfs_pop;
    logic     empty_upd;
    logic     leaf_take;
    logic     leaf_d;
    logic     leaf_dist;
    logic     leaf_cmp;
    logic     nf_load;
    nf_src_t  nf_src;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic illegal;
    logic is_write;
    logic entry_zero;
    logic last_level;
    logic idx_done;
    logic leaf_parent;
    logic root;
    logic child_hit;
    logic empty_cand;
    logic have_empty;
    logic have_room;
    logic cnt_done;
    logic clr_done;
    logic out_busy;
  } sts_t;

endpackage

// ----- sv/ptwfe_ram.sv -----
// generic single write port ram with registered read
module ptwfe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/ptwfe_dp.sv -----
// datapath: request register, walk and search registers, table stack, memories
module ptwfe_dp #(
  parameter int OFFSET_BITS        = ptwfe_pkg::OFFSET_BITS,
  parameter int TABLE_LEVELS       = ptwfe_pkg::TABLE_LEVELS,
  parameter int FRAME_ADDRESS_BITS = ptwfe_pkg::FRAME_ADDRESS_BITS,
  parameter int DATA_BITS          = ptwfe_pkg::DATA_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  ptwfe_pkg::req_t   req,
  input  logic              rsp_ready,
  output logic              rsp_valid,
  output ptwfe_pkg::rsp_t   rsp,
  input  ptwfe_pkg::cmd_t   cmd,
  output ptwfe_pkg::sts_t   sts
);

  localparam int FB          = FRAME_ADDRESS_BITS - OFFSET_BITS;
  localparam int FRAME_COUNT = 1 << FB;
  localparam int PAGE_BITS   = OFFSET_BITS * TABLE_LEVELS;
  localparam int VADDR_BITS  = PAGE_BITS + OFFSET_BITS;
  localparam int VW          = (VADDR_BITS > ptwfe_pkg::VA_BITS) ? VADDR_BITS
                                                                 : ptwfe_pkg::VA_BITS;
  localparam int LW          = $clog2(TABLE_LEVELS + 1);
  localparam int DLW         = (TABLE_LEVELS > 1) ? $clog2(TABLE_LEVELS) : 1;
  localparam bit NO_ROOM     = (FRAME_COUNT <= TABLE_LEVELS);

  ptwfe_pkg::req_t rq;
  ptwfe_pkg::rsp_t rsp_q;
  ptwfe_pkg::rsp_t rsp_next;

  logic [VW-1:0]               va;
  logic [FB-1:0]               cur;
  logic [LW-1:0]               lvl;
  logic [FB-1:0]               parent;
  logic [FB-1:0]               nf;
  logic [FB-1:0]               highest;
  logic [FB:0]                 spare_frame;
  logic [FB-1:0]               best_frame;
  logic [PAGE_BITS-1:0]        best_page;
  logic [PAGE_BITS:0]          best_dist;
  logic [FB-1:0]               leaf_frame;
  logic [PAGE_BITS-1:0]        d_reg;
  logic [PAGE_BITS:0]          wrap_dist;
  logic [OFFSET_BITS:0]        cnt;
  logic [VADDR_BITS:0]         clr_cnt;
  logic [FB-1:0]               stk_frame [TABLE_LEVELS];
  logic [OFFSET_BITS:0]        stk_idx   [TABLE_LEVELS];
  logic                        stk_empty [TABLE_LEVELS];
  logic [DLW-1:0]              dl;
  logic [DLW-1:0]              dl_up;
  logic [DLW-1:0]              dl_dn;

  logic [DATA_BITS-1:0]        fm_q;
  logic [DATA_BITS-1:0]        sw_q;
  logic [FRAME_ADDRESS_BITS-1:0] fm_addr;
  logic [DATA_BITS-1:0]        fm_wdata;
  logic                        fm_we;
  logic [VADDR_BITS-1:0]       sw_addr;
  logic [DATA_BITS-1:0]        sw_wdata;

  logic [FB-1:0]               child;
  logic [FB-1:0]               top_frame;
  logic [OFFSET_BITS:0]        top_idx;
  logic [OFFSET_BITS-1:0]      walk_idx;
  logic [PAGE_BITS-1:0]        path;
  logic [PAGE_BITS-1:0]        page;
  logic [PAGE_BITS:0]          alt;
  logic [PAGE_BITS:0]          d_ext;

  assign va        = VW'(rq.vaddr);
  assign page      = va[OFFSET_BITS +: PAGE_BITS];
  assign child     = fm_q[FB-1:0];
  assign top_frame = stk_frame[dl];
  assign top_idx   = stk_idx[dl];
  assign dl_up     = dl + DLW'(1);
  assign dl_dn     = dl - DLW'(1);
  assign d_ext     = {1'b0, d_reg};
  assign alt       = {1'b1, {PAGE_BITS{1'b0}}} - d_ext;

  // table index at the current walk level, most significant level first
  always_comb begin
    walk_idx = '0;
    for (int k = 0; k < TABLE_LEVELS; k++) begin
      if (lvl == LW'(k)) begin
        walk_idx = va[(TABLE_LEVELS - k) * OFFSET_BITS +: OFFSET_BITS];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < TABLE_LEVELS; k++) begin
      path[(TABLE_LEVELS - 1 - k) * OFFSET_BITS +: OFFSET_BITS] = stk_idx[k][OFFSET_BITS-1:0];
    end
  end

  always_comb begin
    unique case (cmd.fm_addr)
      ptwfe_pkg::FA_WALK: fm_addr = {cur, walk_idx};
      ptwfe_pkg::FA_DFS:  fm_addr = {top_frame, top_idx[OFFSET_BITS-1:0]};
      ptwfe_pkg::FA_NF:   fm_addr = {nf, cnt[OFFSET_BITS-1:0]};
      ptwfe_pkg::FA_CUR:  fm_addr = {cur, cnt[OFFSET_BITS-1:0]};
      ptwfe_pkg::FA_PA:   fm_addr = {cur, va[OFFSET_BITS-1:0]};
      ptwfe_pkg::FA_CLR:  fm_addr = {{FB{1'b0}}, clr_cnt[OFFSET_BITS-1:0]};
      default:            fm_addr = '0;
    endcase
    unique case (cmd.fm_wsel)
      ptwfe_pkg::FW_ZERO: fm_wdata = '0;
      ptwfe_pkg::FW_NF:   fm_wdata = DATA_BITS'(nf);
      ptwfe_pkg::FW_SWAP: fm_wdata = sw_q;
      ptwfe_pkg::FW_DATA: fm_wdata = DATA_BITS'(rq.write_data);
      default:            fm_wdata = '0;
    endcase
    unique case (cmd.sw_addr)
      ptwfe_pkg::SA_CLR: sw_addr = clr_cnt[VADDR_BITS-1:0];
      ptwfe_pkg::SA_OUT: sw_addr = {best_page, cnt[OFFSET_BITS-1:0]};
      ptwfe_pkg::SA_IN:  sw_addr = {page, cnt[OFFSET_BITS-1:0]};
      default:           sw_addr = '0;
    endcase
  end

  // the clearing pass only touches frame zero on its first page of steps
  assign fm_we = cmd.fm_we && ((cmd.fm_addr != ptwfe_pkg::FA_CLR) ||
                               (clr_cnt[VADDR_BITS-1:OFFSET_BITS] == '0));
  assign sw_wdata = (cmd.sw_addr == ptwfe_pkg::SA_CLR) ? '0 : fm_q;

  ptwfe_ram #(
    .WIDTH (DATA_BITS),
    .DEPTH (1 << FRAME_ADDRESS_BITS)
  ) u_frame_ram (
    .clk   (clk),
    .we    (fm_we),
    .waddr (fm_addr),
    .wdata (fm_wdata),
    .re    (cmd.fm_re),
    .raddr (fm_addr),
    .rdata (fm_q)
  );

  ptwfe_ram #(
    .WIDTH (DATA_BITS),
    .DEPTH (2 ** VADDR_BITS)
  ) u_swap_ram (
    .clk   (clk),
    .we    (cmd.sw_we),
    .waddr (sw_addr),
    .wdata (sw_wdata),
    .re    (cmd.sw_re),
    .raddr (sw_addr),
    .rdata (sw_q)
  );

  always_comb begin
    rsp_next = '0;
    if (!sts.illegal) begin
      rsp_next.physical_address = ptwfe_pkg::PA_BITS'({cur, va[OFFSET_BITS-1:0]});
      if (!rq.kind) begin
        rsp_next.read_data = ptwfe_pkg::WORD_BITS'(fm_q);
      end
    end else begin
      rsp_next.status = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      rq <= req;
    end
    if (cmd.out_load) begin
      rsp_q <= rsp_next;
    end
    if (cmd.walk_start) begin
      cur <= '0;
      lvl <= '0;
    end
    if (cmd.walk_adv) begin
      cur <= child;
      lvl <= lvl + 1'b1;
    end
    if (cmd.link) begin
      cur <= nf;
      lvl <= lvl + 1'b1;
    end
    if (cmd.search_init) begin
      best_frame  <= '0;
      best_page   <= '0;
      best_dist   <= '0;
      highest     <= '0;
      spare_frame <= (FB + 1)'(FRAME_COUNT);
      parent      <= cur;
    end
    if (cmd.dfs_init) begin
      dl           <= '0;
      stk_frame[0] <= '0;
      stk_idx[0]   <= '0;
      stk_empty[0] <= 1'b1;
    end
    if (cmd.dfs_mark) begin
      stk_empty[dl] <= 1'b0;
      if (child > highest) begin
        highest <= child;
      end
    end
    if (cmd.dfs_push) begin
      dl               <= dl_up;
      stk_frame[dl_up] <= child;
      stk_idx[dl_up]   <= '0;
      stk_empty[dl_up] <= 1'b1;
    end
    if (cmd.dfs_next) begin
      stk_idx[dl] <= top_idx + 1'b1;
    end
    if (cmd.dfs_pop) begin
      dl             <= dl_dn;
      stk_idx[dl_dn] <= stk_idx[dl_dn] + 1'b1;
    end
    if (cmd.empty_upd && sts.empty_cand) begin
      spare_frame <= {1'b0, top_frame};
    end
    if (cmd.leaf_take) begin
      leaf_frame <= child;
    end
    if (cmd.leaf_d) begin
      d_reg <= (page > path) ? (page - path) : (path - page);
    end
    if (cmd.leaf_dist) begin
      wrap_dist <= (alt < d_ext) ? alt : d_ext;
    end
    if (cmd.leaf_cmp && (wrap_dist > best_dist)) begin
      best_dist  <= wrap_dist;
      best_page  <= path;
      best_frame <= leaf_frame;
    end
    if (cmd.nf_load) begin
      unique case (cmd.nf_src)
        ptwfe_pkg::NF_EMPTY: nf <= spare_frame[FB-1:0];
        ptwfe_pkg::NF_HIGH:  nf <= highest + 1'b1;
        ptwfe_pkg::NF_BEST:  nf <= best_frame;
        default:             nf <= best_frame;
      endcase
    end
    if (cmd.cnt_clr) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + 1'b1;
    end
  end

  assign rsp = rsp_q;

  always_comb begin
    sts             = '0;
    sts.illegal     = ((va >> VADDR_BITS) != '0) || NO_ROOM;
    sts.is_write    = rq.kind;
    sts.entry_zero  = (fm_q == '0);
    sts.last_level  = (lvl == LW'(TABLE_LEVELS - 1));
    sts.idx_done    = top_idx[OFFSET_BITS];
    sts.leaf_parent = (dl == DLW'(TABLE_LEVELS - 1));
    sts.root        = (dl == '0);
    sts.child_hit   = (child == nf);
    sts.empty_cand  = stk_empty[dl] && (top_frame != parent) &&
                      ({1'b0, top_frame} < spare_frame);
    sts.have_empty  = !spare_frame[FB];
    sts.have_room   = (highest != {FB{1'b1}});
    sts.cnt_done    = cnt[OFFSET_BITS];
    sts.clr_done    = clr_cnt[VADDR_BITS];
    sts.out_busy    = rsp_valid && !rsp_ready;
  end

endmodule

// ----- sv/ptwfe_ctrl.sv -----
// controller: walk, tree search, unlink, swap and fill sequencing
module ptwfe_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  ptwfe_pkg::sts_t sts,
  output ptwfe_pkg::cmd_t cmd
);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_CHK, S_WRD, S_WEVAL, S_TFI, S_DRD, S_DEVAL, S_DEND,
    S_LF1, S_LF2, S_LF3, S_DEC, S_SORD, S_SOWR, S_TFL, S_ZERO, S_LINK,
    S_RSRD, S_RSWR, S_ACC, S_OUT
  } state_t;

  state_t state;
  state_t state_next;
  logic   unl;
  logic   unl_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unl_next   = unl;
    unique case (state)
      S_CLR: begin
        if (sts.clr_done) begin
          state_next = S_IDLE;
        end else begin
          cmd.sw_we    = 1'b1;
          cmd.sw_addr  = ptwfe_pkg::SA_CLR;
          cmd.fm_we    = 1'b1;
          cmd.fm_addr  = ptwfe_pkg::FA_CLR;
          cmd.fm_wsel  = ptwfe_pkg::FW_ZERO;
          cmd.clr_step = 1'b1;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.take_in = 1'b1;
          state_next  = S_CHK;
        end
      end
      S_CHK: begin
        if (sts.illegal) begin
          state_next = S_OUT;
        end else begin
          cmd.walk_start = 1'b1;
          state_next     = S_WRD;
        end
      end
      S_WRD: begin
        cmd.fm_re   = 1'b1;
        cmd.fm_addr = ptwfe_pkg::FA_WALK;
        state_next  = S_WEVAL;
      end
      S_WEVAL: begin
        if (sts.entry_zero) begin
          state_next = S_TFI;
        end else begin
          cmd.walk_adv = 1'b1;
          state_next   = sts.last_level ? S_ACC : S_WRD;
        end
      end
      S_TFI: begin
        cmd.search_init = 1'b1;
        cmd.dfs_init    = 1'b1;
        unl_next        = 1'b0;
        state_next      = S_DRD;
      end
      S_DRD: begin
        if (sts.idx_done) begin
          state_next = S_DEND;
        end else begin
          cmd.fm_re   = 1'b1;
          cmd.fm_addr = ptwfe_pkg::FA_DFS;
          state_next  = S_DEVAL;
        end
      end
      S_DEVAL: begin
        priority if (sts.entry_zero) begin
          cmd.dfs_next = 1'b1;
          state_next   = S_DRD;
        end else if (!unl) begin
          cmd.dfs_mark = 1'b1;
          if (sts.leaf_parent) begin
            cmd.leaf_take = 1'b1;
            state_next    = S_LF1;
          end else begin
            cmd.dfs_push = 1'b1;
            state_next   = S_DRD;
          end
        end else if (sts.child_hit) begin
          // clear the link and leave this table
          cmd.fm_we   = 1'b1;
          cmd.fm_addr = ptwfe_pkg::FA_DFS;
          cmd.fm_wsel = ptwfe_pkg::FW_ZERO;
          if (sts.root) begin
            state_next = S_TFL;
          end else begin
            cmd.dfs_pop = 1'b1;
            state_next  = S_DRD;
          end
        end else if (sts.leaf_parent) begin
          cmd.dfs_next = 1'b1;
          state_next   = S_DRD;
        end else begin
          cmd.dfs_push = 1'b1;
          state_next   = S_DRD;
        end
      end
      S_DEND: begin
        cmd.empty_upd = !unl;
        if (sts.root) begin
          state_next = unl ? S_TFL : S_DEC;
        end else begin
          cmd.dfs_pop = 1'b1;
          state_next  = S_DRD;
        end
      end
      S_LF1: begin
        cmd.leaf_d = 1'b1;
        state_next = S_LF2;
      end
      S_LF2: begin
        cmd.leaf_dist = 1'b1;
        state_next    = S_LF3;
      end
      S_LF3: begin
        cmd.leaf_cmp = 1'b1;
        cmd.dfs_next = 1'b1;
        state_next   = S_DRD;
      end
      S_DEC: begin
        cmd.nf_load = 1'b1;
        priority if (sts.have_empty) begin
          cmd.nf_src   = ptwfe_pkg::NF_EMPTY;
          cmd.dfs_init = 1'b1;
          unl_next     = 1'b1;
          state_next   = S_DRD;
        end else if (sts.have_room) begin
          cmd.nf_src = ptwfe_pkg::NF_HIGH;
          state_next = S_TFL;
        end else begin
          cmd.nf_src  = ptwfe_pkg::NF_BEST;
          cmd.cnt_clr = 1'b1;
          state_next  = S_SORD;
        end
      end
      S_SORD: begin
        if (sts.cnt_done) begin
          cmd.dfs_init = 1'b1;
          unl_next     = 1'b1;
          state_next   = S_DRD;
        end else begin
          cmd.fm_re   = 1'b1;
          cmd.fm_addr = ptwfe_pkg::FA_NF;
          state_next  = S_SOWR;
        end
      end
      S_SOWR: begin
        cmd.sw_we   = 1'b1;
        cmd.sw_addr = ptwfe_pkg::SA_OUT;
        cmd.cnt_inc = 1'b1;
        state_next  = S_SORD;
      end
      S_TFL: begin
        if (sts.last_level) begin
          state_next = S_LINK;
        end else begin
          cmd.cnt_clr = 1'b1;
          state_next  = S_ZERO;
        end
      end
      S_ZERO: begin
        if (sts.cnt_done) begin
          state_next = S_LINK;
        end else begin
          cmd.fm_we   = 1'b1;
          cmd.fm_addr = ptwfe_pkg::FA_NF;
          cmd.fm_wsel = ptwfe_pkg::FW_ZERO;
          cmd.cnt_inc = 1'b1;
        end
      end
      S_LINK: begin
        cmd.fm_we   = 1'b1;
        cmd.fm_addr = ptwfe_pkg::FA_WALK;
        cmd.fm_wsel = ptwfe_pkg::FW_NF;
        cmd.link    = 1'b1;
        if (sts.last_level) begin
          cmd.cnt_clr = 1'b1;
          state_next  = S_RSRD;
        end else begin
          state_next = S_WRD;
        end
      end
      S_RSRD: begin
        if (sts.cnt_done) begin
          state_next = S_ACC;
        end else begin
          cmd.sw_re   = 1'b1;
          cmd.sw_addr = ptwfe_pkg::SA_IN;
          state_next  = S_RSWR;
        end
      end
      S_RSWR: begin
        cmd.fm_we   = 1'b1;
        cmd.fm_addr = ptwfe_pkg::FA_CUR;
        cmd.fm_wsel = ptwfe_pkg::FW_SWAP;
        cmd.cnt_inc = 1'b1;
        state_next  = S_RSRD;
      end
      S_ACC: begin
        cmd.fm_addr = ptwfe_pkg::FA_PA;
        cmd.fm_wsel = ptwfe_pkg::FW_DATA;
        cmd.fm_we   = sts.is_write;
        cmd.fm_re   = !sts.is_write;
        state_next  = S_OUT;
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      unl   <= 1'b0;
    end else begin
      state <= state_next;
      unl   <= unl_next;
    end
  end

  a_push_depth: assert property (@(posedge clk) disable iff (rst)
    cmd.dfs_push |-> !sts.leaf_parent)
    else $error("table stack pushed past the last table level");

  a_pop_root: assert property (@(posedge clk) disable iff (rst)
    cmd.dfs_pop |-> !sts.root)
    else $error("table stack popped at the root");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !sts.out_busy)
    else $error("result register overwritten while held");

  a_take_chk: assert property (@(posedge clk) disable iff (rst)
    cmd.take_in |=> (state == S_CHK) && !req_ready)
    else $error("accepted beat not followed by the address check");

endmodule

// ----- sv/page_table_walk_with_frame_eviction_unit.sv -----
// top level: page table walker with demand paging and frame eviction
//
//  channel | dir | payload         | handshake
//  req     | in  | ptwfe_pkg::req_t | req_valid / req_ready
//  rsp     | out | ptwfe_pkg::rsp_t | rsp_valid / rsp_ready
//
// one request at a time; a resident page is walked level by level from accept to
// result valid, an illegal address skips the walk
// a missing entry scans the table tree through the single frame ram port, then
// unlinks an empty table (another tree pass), or takes a fresh frame, or swaps out
// a victim leaf and unlinks it, then zeroes a new table or restores a leaf word
// by word from the swap store
// after reset a clearing pass zeroes the swap store and frame zero with
// req_ready low
// the result register holds a beat while rsp_ready is low; the next request is
// taken and walked but waits to load its result
module page_table_walk_with_frame_eviction_unit #(
  parameter int OFFSET_BITS        = ptwfe_pkg::OFFSET_BITS,
  parameter int TABLE_LEVELS       = ptwfe_pkg::TABLE_LEVELS,
  parameter int FRAME_ADDRESS_BITS = ptwfe_pkg::FRAME_ADDRESS_BITS,
  parameter int DATA_BITS          = ptwfe_pkg::DATA_BITS
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  ptwfe_pkg::req_t req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output ptwfe_pkg::rsp_t rsp
);

  ptwfe_pkg::cmd_t cmd;
  ptwfe_pkg::sts_t sts;

  ptwfe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ptwfe_dp #(
    .OFFSET_BITS        (OFFSET_BITS),
    .TABLE_LEVELS       (TABLE_LEVELS),
    .FRAME_ADDRESS_BITS (FRAME_ADDRESS_BITS),
    .DATA_BITS          (DATA_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp_ready (rsp_ready),
    .rsp_valid (rsp_valid),
    .rsp       (rsp),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ----- bench/tb_page_table_walk_with_frame_eviction_unit.sv -----
// testbench for the page table walker: directed table, then random traffic against a predictor
module tb_page_table_walk_with_frame_eviction_unit;

  localparam int OFFSET_BITS        = ptwfe_pkg::OFFSET_BITS;
  localparam int TABLE_LEVELS       = ptwfe_pkg::TABLE_LEVELS;
  localparam int FRAME_ADDRESS_BITS = ptwfe_pkg::FRAME_ADDRESS_BITS;

  localparam int PAGE_WORDS   = 1 << OFFSET_BITS;
  localparam int FRAMES       = 1 << (FRAME_ADDRESS_BITS - OFFSET_BITS);
  localparam int MEM_WORDS    = 1 << FRAME_ADDRESS_BITS;
  localparam int VA_SPACE     = OFFSET_BITS * (TABLE_LEVELS + 1);
  localparam int PAGE_SPAN    = 1 << (OFFSET_BITS * TABLE_LEVELS);
  localparam int RANDOM_ITEMS = 124;
  localparam int HOLD_CYCLES  = 3000;
  localparam longint CYCLE_LIMIT = 20_000_000;

  localparam bit RD = 1'b0;
  localparam bit WR = 1'b1;
  localparam bit ST_DONE    = 1'b0;
  localparam bit ST_ILLEGAL = 1'b1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  ptwfe_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  ptwfe_pkg::rsp_t rsp;

  page_table_walk_with_frame_eviction_unit dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  always #2 clk = ~clk;

  longint cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout waiting for the walker", $time);
      $display("page_table_walk_with_frame_eviction_unit test failed");
      $finish;
    end
  end

  // predictor state
  logic [31:0] frame_words[MEM_WORDS];
  logic [31:0] swapped[int unsigned];
  int unsigned best_frame, best_page, best_dist, highest_frame, spare_frame;

  ptwfe_pkg::rsp_t expected_rsp[$];
  int errors = 0, checked = 0, n_writes = 0, n_illegal = 0, n_sent = 0;
  bit hold_req = 0, quiet = 0;

  function automatic logic [31:0] word_at(int unsigned fr, int unsigned idx);
    return frame_words[(fr * PAGE_WORDS + idx) % MEM_WORDS];
  endfunction

  function automatic void word_put(int unsigned fr, int unsigned idx, logic [31:0] v);
    frame_words[(fr * PAGE_WORDS + idx) % MEM_WORDS] = v;
  endfunction

  function automatic logic [31:0] swap_word(int unsigned a);
    if (swapped.exists(a)) return swapped[a];
    return '0;
  endfunction

  function automatic void scan_tree(int unsigned fr, int lvl, int unsigned path,
                                    int unsigned parent, int unsigned pg);
    bit empty;
    logic [31:0] e;
    int unsigned d;
    empty = 1;
    if (fr > highest_frame) highest_frame = fr;
    if (lvl >= TABLE_LEVELS) begin
      d = (pg > path) ? pg - path : path - pg;
      if (PAGE_SPAN - d < d) d = PAGE_SPAN - d;
      if (d > best_dist) begin
        best_dist = d;
        best_page = path;
        best_frame = fr;
      end
      return;
    end
    for (int i = 0; i < PAGE_WORDS; i++) begin
      e = word_at(fr, i);
      if (e == 0) continue;
      empty = 0;
      scan_tree(e % FRAMES, lvl + 1, ((path << OFFSET_BITS) | i) % PAGE_SPAN, parent, pg);
    end
    if (empty && fr != parent && fr < spare_frame) spare_frame = fr;
  endfunction

  function automatic void unlink_tree(int unsigned target, int unsigned fr, int lvl);
    logic [31:0] e;
    if (lvl >= TABLE_LEVELS) return;
    for (int i = 0; i < PAGE_WORDS; i++) begin
      e = word_at(fr, i);
      if (e == 0) continue;
      if (e % FRAMES == target) begin
        word_put(fr, i, '0);
        return;
      end
      unlink_tree(target, e % FRAMES, lvl + 1);
    end
  endfunction

  // pick a frame: empty table, then fresh frame, then evict the farthest leaf
  function automatic int unsigned claim_frame(int unsigned parent, int unsigned pg);
    best_frame = 0; best_page = 0; best_dist = 0; highest_frame = 0;
    spare_frame = FRAMES;
    scan_tree(0, 0, 0, parent, pg);
    if (spare_frame != FRAMES) begin
      unlink_tree(spare_frame, 0, 0);
      return spare_frame;
    end
    if (highest_frame < FRAMES - 1) return highest_frame + 1;
    for (int i = 0; i < PAGE_WORDS; i++)
      swapped[((best_page << OFFSET_BITS) | i) % (1 << VA_SPACE)] = word_at(best_frame, i);
    unlink_tree(best_frame, 0, 0);
    return best_frame;
  endfunction

  function automatic ptwfe_pkg::rsp_t translate_access(ptwfe_pkg::req_t r);
    ptwfe_pkg::rsp_t o;
    int unsigned va, pg, cur, idx, nf, pa;
    logic [31:0] e;
    bit fresh;
    o = '0;
    va = r.vaddr;
    if ((va >> VA_SPACE) != 0 || FRAMES <= TABLE_LEVELS) begin
      o.status = ST_ILLEGAL;
      return o;
    end
    cur = 0; fresh = 0;
    pg = va >> OFFSET_BITS;
    for (int lvl = 0; lvl < TABLE_LEVELS; lvl++) begin
      idx = (va >> ((TABLE_LEVELS - lvl) * OFFSET_BITS)) % PAGE_WORDS;
      e = word_at(cur, idx);
      if (e == 0) begin
        nf = claim_frame(cur, pg);
        if (lvl < TABLE_LEVELS - 1) begin
          for (int i = 0; i < PAGE_WORDS; i++) word_put(nf, i, '0);
        end else begin
          fresh = 1;
        end
        word_put(cur, idx, nf);
        e = nf;
      end
      cur = e % FRAMES;
    end
    if (fresh) begin
      for (int i = 0; i < PAGE_WORDS; i++)
        word_put(cur, i, swap_word(((pg << OFFSET_BITS) | i) % (1 << VA_SPACE)));
    end
    pa = (cur * PAGE_WORDS + va % PAGE_WORDS) % MEM_WORDS;
    o.status = ST_DONE;
    o.physical_address = ptwfe_pkg::PA_BITS'(pa);
    if (r.kind == RD) o.read_data = frame_words[pa];
    else frame_words[pa] = r.write_data;
    return o;
  endfunction

  // offer one beat after an idle gap; keep valid high when no gap follows
  task automatic send_req(ptwfe_pkg::req_t r, int gap, bit pinned,
                          ptwfe_pkg::rsp_t pinned_rsp);
    ptwfe_pkg::rsp_t p;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (!req_ready);
    p = translate_access(r);
    expected_rsp.push_back(pinned ? pinned_rsp : p);
    n_sent++;
    if (r.kind == WR) n_writes++;
    if (p.status == ST_ILLEGAL) n_illegal++;
  endtask

  // receiver with random stalls and one long hold-off
  initial begin
    int stall;
    ptwfe_pkg::rsp_t want;
    forever begin
      if (hold_req) begin
        hold_req = 0;
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        stall = quiet ? 0 : $urandom_range(0, 9);
        if (stall > 0) begin
          rsp_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!rsp_valid || rst);
      checked++;
      if (expected_rsp.size() == 0) begin
        errors++;
        $display("%0t unexpected beat: actual %p", $time, rsp);
      end else begin
        want = expected_rsp.pop_front();
        if (rsp.status !== want.status || rsp.read_data !== want.read_data ||
            rsp.physical_address !== want.physical_address) begin
          errors++;
          $display("%0t mismatch: expected status %0d data %h pa %0d, actual status %0d data %h pa %0d",
                   $time, want.status, want.read_data, want.physical_address,
                   rsp.status, rsp.read_data, rsp.physical_address);
        end
      end
    end
  end

  typedef struct {
    bit              kind;
    logic [31:0]     va;
    logic [31:0]     wd;
    bit              pinned;
    ptwfe_pkg::rsp_t want;
  } access_row_t;

  localparam ptwfe_pkg::rsp_t NONE    = '0;
  localparam ptwfe_pkg::rsp_t BAD     = '{status: ST_ILLEGAL, read_data: 0,
                                          physical_address: 0};
  localparam ptwfe_pkg::rsp_t FIRST   = '{status: ST_DONE, read_data: 0,
                                          physical_address: 64};
  localparam ptwfe_pkg::rsp_t MAXWORD = '{status: ST_DONE, read_data: 32'h7fffffff,
                                          physical_address: 64};

  // after reset the first walk takes frames 1..4, so word 0 lands at 64
  access_row_t directed[] = '{
    '{RD, 32'h0000_0000, 32'h0,         1, FIRST},
    '{WR, 32'h0000_0000, 32'h7fffffff,  1, FIRST},
    '{RD, 32'h0000_0000, 32'h0,         1, MAXWORD},
    '{RD, 32'h0010_0000, 32'h0,         1, BAD},
    '{WR, 32'hffff_ffff, 32'hffffffff,  1, BAD},
    '{RD, 32'h8000_0000, 32'h0,         1, BAD},
    '{RD, 32'h000f_ffff, 32'h0,         0, NONE},
    '{WR, 32'h000f_ffff, 32'h80000000,  0, NONE},
    '{RD, 32'h000f_ffff, 32'h0,         0, NONE},
    '{WR, 32'h0000_000f, 32'hffffffff,  0, NONE},
    '{RD, 32'h0000_000f, 32'h0,         0, NONE},
    '{WR, 32'h0001_2345, 32'h5a5a5a5a,  0, NONE},
    '{RD, 32'h0001_2345, 32'h0,         0, NONE},
    '{RD, 32'h0005_4321, 32'h0,         0, NONE},
    '{WR, 32'h0008_0000, 32'ha5a5a5a5,  0, NONE},
    '{RD, 32'h0008_0000, 32'h0,         0, NONE}
  };

  initial begin
    ptwfe_pkg::req_t r;
    int unsigned pool[24];
    int pick;
    foreach (frame_words[i]) frame_words[i] = '0;
    foreach (pool[i]) pool[i] = $urandom_range(0, PAGE_SPAN - 1);
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      r.kind = directed[i].kind;
      r.vaddr = directed[i].va;
      r.write_data = directed[i].wd;
      send_req(r, $urandom_range(0, 9), directed[i].pinned, directed[i].want);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 40) hold_req = 1;
      if (n == 90) begin
        req_valid <= 1'b0;
        wait (expected_rsp.size() == 0);
        @(posedge clk);
      end
      quiet = (n >= 100 && n < 120);
      r.kind = 1'($urandom_range(0, 1));
      r.write_data = $urandom;
      pick = $urandom_range(0, 99);
      // mostly revisits of a page pool so evicted pages come back from swap
      if (pick < 60)
        r.vaddr = (pool[$urandom_range(0, 23)] << OFFSET_BITS)
                  | $urandom_range(0, PAGE_WORDS - 1);
      else if (pick < 85)
        r.vaddr = $urandom_range(0, (1 << VA_SPACE) - 1);
      else
        r.vaddr = $urandom | (32'h1 << $urandom_range(VA_SPACE, 31));
      send_req(r, quiet ? 0 : $urandom_range(0, 9), 0, NONE);
    end
    req_valid <= 1'b0;

    wait (expected_rsp.size() == 0);
    repeat (200) @(posedge clk);
    $display("sent %0d accesses (%0d writes, %0d illegal), %0d result beats checked",
             n_sent, n_writes, n_illegal, checked);
    $display("swap store holds %0d evicted words", swapped.size());
    if (errors == 0 && expected_rsp.size() == 0) begin
      $display("page_table_walk_with_frame_eviction_unit test passed");
    end else begin
      $display("page_table_walk_with_frame_eviction_unit test failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/ptwfe_pkg.sv
sv/ptwfe_ram.sv
sv/ptwfe_dp.sv
sv/ptwfe_ctrl.sv
sv/page_table_walk_with_frame_eviction_unit.sv
bench/tb_page_table_walk_with_frame_eviction_unit.sv
